FILE: sv/gpm_pkg.sv
// ----------------------------------------------------------------------------
// gpm_pkg
// Shared types and constants of the glob pattern matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package gpm_pkg;

  localparam int unsigned MAX_PATTERN_DEF = 32;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_ANY   = 8'h3F;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;

  localparam logic [1:0] REQ_PATTERN = 2'd0;
  localparam logic [1:0] REQ_STRING  = 2'd1;
  localparam logic [1:0] REQ_END     = 2'd2;
  localparam logic [1:0] REQ_NONE    = 2'd3;

  typedef enum logic [1:0] {
    OP_PATTERN,
    OP_STRING,
    OP_END
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       first;
    logic [7:0] char_byte;
  } item_t;

endpackage

`default_nettype wire

FILE: sv/gpm_front.sv
// ----------------------------------------------------------------------------
// gpm_front
// Accepts input items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module gpm_front
  import gpm_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,  // [7:0] char_byte
  input  wire logic [2:0] s_axis_tuser_i,  // [1:0] req_type, [2] first
  output logic            q_valid_o,
  output item_t           q_item_o,
  input  wire logic       q_pop_i
);

  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       keep;
  logic       push;
  item_t      item;

  always_comb begin
    keep = 1'b1;
    item.first     = s_axis_tuser_i[2];
    item.char_byte = s_axis_tdata_i;
    item.op        = OP_PATTERN;
    unique case (s_axis_tuser_i[1:0])
      REQ_PATTERN: item.op = OP_PATTERN;
      REQ_STRING:  item.op = OP_STRING;
      REQ_END:     item.op = OP_END;
      default:     keep = 1'b0;
    endcase
  end

  assign s_axis_tready_o = (cnt_q != 2'd2);
  assign push            = s_axis_tvalid_i && s_axis_tready_o && keep;
  assign q_valid_o       = (cnt_q != 2'd0);
  assign q_item_o        = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

endmodule

`default_nettype wire

FILE: sv/gpm_engine.sv
// ----------------------------------------------------------------------------
// gpm_engine
// Pattern store and bit-parallel NFA update; registers one result per end item.
// ----------------------------------------------------------------------------
`default_nettype none

module gpm_engine
  import gpm_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       q_valid_i,
  input  wire item_t      q_item_i,
  output logic            q_pop_o,
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o  // [0] matched, [1] pattern_overflow
);

  localparam int unsigned N  = MAX_PATTERN + 1;
  localparam int unsigned LW = $clog2(N);
  localparam int unsigned IW = $clog2(MAX_PATTERN);

  function automatic logic [N-1:0] seg_scan(input logic [N-1:0] g, input logic [N-1:0] p);
    logic [N-1:0] gg, pp, gn, pn;
    gg = g;
    pp = p;
    for (int d = 1; d < N; d = d * 2) begin
      gn = gg;
      pn = pp;
      for (int i = d; i < N; i++) begin
        gn[i] = gg[i] | (pp[i] & gg[i-d]);
        pn[i] = pp[i] & pp[i-d];
      end
      gg = gn;
      pp = pn;
    end
    return gg;
  endfunction

  logic [7:0]    store_q [MAX_PATTERN];
  logic [LW-1:0] len_q, len_d, len_eff;
  logic [N-1:0]  act_q, act_d;
  logic          ovf_q, ovf_d;
  logic          out_valid_q, matched_q, out_ovf_q;
  logic          out_free;
  logic          do_op;
  logic          wr_en;

  logic [N-1:0] vld, star, any, open, close, eq;
  logic [N-1:0] base, cls, fx, fv, yx, hv, nxt;

  always_comb begin
    vld = '0; star = '0; any = '0; open = '0; close = '0; eq = '0;
    for (int p = 0; p < MAX_PATTERN; p++) begin
      vld[p]   = (LW'(p) < len_q);
      star[p]  = vld[p] && (store_q[p] == CH_STAR);
      any[p]   = vld[p] && (store_q[p] == CH_ANY);
      open[p]  = vld[p] && (store_q[p] == CH_OPEN);
      close[p] = vld[p] && (store_q[p] == CH_CLOSE);
      eq[p]    = vld[p] && (store_q[p] == q_item_i.char_byte);
    end
  end

  // star closure, then pending-class and class-hit scans inside ']' segments
  always_comb begin
    base = q_item_i.first ? N'(1) : act_q;
    cls  = seg_scan(base, {star[N-2:0], 1'b0});
    fx   = seg_scan(~close & open & cls, ~close);
    fv   = {fx[N-2:0], 1'b0};
    yx   = seg_scan(~close & fv & eq, ~close);
    hv   = {yx[N-2:0], 1'b0};
    nxt  = '0;
    for (int p = 0; p < MAX_PATTERN; p++) begin
      if (star[p] && cls[p]) begin
        nxt[p] = 1'b1;
      end
      if (cls[p] && (any[p] || (eq[p] && !star[p] && !open[p]))) begin
        nxt[p+1] = 1'b1;
      end
      if (close[p] && hv[p]) begin
        nxt[p+1] = 1'b1;
      end
    end
  end

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign q_pop_o  = q_valid_i && ((q_item_i.op != OP_END) || out_free);
  assign do_op    = q_pop_o;

  always_comb begin
    len_d   = len_q;
    ovf_d   = ovf_q;
    act_d   = act_q;
    wr_en   = 1'b0;
    len_eff = q_item_i.first ? '0 : len_q;
    if (do_op) begin
      case (q_item_i.op)
        OP_PATTERN: begin
          if (q_item_i.first) begin
            ovf_d = 1'b0;
          end
          if (len_eff == LW'(MAX_PATTERN)) begin
            ovf_d = 1'b1;
            len_d = len_eff;
          end else begin
            wr_en = 1'b1;
            len_d = len_eff + LW'(1);
          end
          act_d = N'(1);
        end
        OP_STRING: act_d = nxt;
        OP_END:    act_d = cls;
        default:   act_d = act_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[len_eff[IW-1:0]] <= q_item_i.char_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      ovf_q       <= 1'b0;
      act_q       <= N'(1);
      out_valid_q <= 1'b0;
      matched_q   <= 1'b0;
      out_ovf_q   <= 1'b0;
    end else begin
      len_q <= len_d;
      ovf_q <= ovf_d;
      act_q <= act_d;
      if (do_op && (q_item_i.op == OP_END)) begin
        out_valid_q <= 1'b1;
        matched_q   <= cls[len_q] && !ovf_q;
        out_ovf_q   <= ovf_q;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_ovf_q, matched_q};

`ifndef SYNTHESIS
  a_len_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(MAX_PATTERN))
    else $error("pattern length beyond store");
  a_ovf_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (len_q == LW'(MAX_PATTERN)))
    else $error("overflow with store not full");
  a_no_clobber : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && (q_item_i.op == OP_END)) |-> (!out_valid_q || m_axis_tready_i))
    else $error("result overwritten while waiting");
  a_ovf_nomatch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(matched_q && out_ovf_q))
    else $error("match reported with overflow");
`endif

endmodule

`default_nettype wire

FILE: sv/glob_pattern_matcher.sv
// ----------------------------------------------------------------------------
// glob_pattern_matcher
// Glob matcher: '*', '?', '[set]' and literals, one NFA bit per position.
// ----------------------------------------------------------------------------
// Load the pattern as pattern items (first set on its first byte), then stream
// string items and close with an end item, which yields one result. A new
// item is accepted each cycle while the two-entry queue has room. All pattern
// positions update in parallel, so the rate is one item per cycle; an end
// item waits only if the previous result is still held on the output.
`default_nettype none

module glob_pattern_matcher
  import gpm_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,  // [7:0] char_byte
  input  wire logic [2:0] s_axis_tuser,  // [1:0] req_type, [2] first
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata   // [0] matched, [1] pattern_overflow
);

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  gpm_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .q_valid_o       (q_valid),
    .q_item_o        (q_item),
    .q_pop_i         (q_pop)
  );

  gpm_engine #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_item_i        (q_item),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire
